// ===== hw/rtl/psc_pkg.sv =====
`default_nettype none
package psc_pkg;

   localparam int ID_W    = 16;
   localparam int TIME_W  = 32;
   localparam int POS_W   = 24;
   localparam int LIMIT_W = 23;
   localparam int LOOK_W  = 8;

   localparam int DEF_MAX_SLOTS   = 32;
   localparam int MAX_ALERTS      = 62;
   localparam int SECONDS_PER_HOUR = 3600;
   localparam int CMP_LAT         = 3;
   localparam int PROJ_LAT        = 5;

   localparam logic [LIMIT_W-1:0] HLIMIT_RESET = LIMIT_W'(3000);
   localparam logic [LIMIT_W-1:0] VLIMIT_RESET = LIMIT_W'(1000);
   localparam logic [LOOK_W-1:0]  LOOK_RESET   = LOOK_W'(120);

   typedef enum logic [1:0] {
      CSR_HLIMIT = 2'd0,
      CSR_VLIMIT = 2'd1,
      CSR_LOOK   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROJ,
      ST_SCAN,
      ST_EMIT,
      ST_STORE
   } state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } pos_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      pos_type         cur;
      pos_type         pred;
   } slot_type;

endpackage
`default_nettype wire

// ===== hw/rtl/pairwise_separation_checker.sv =====
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// req_     | in        | req_valid/req_stall| frame_start, flight_id, times, pos, vel
// rsp_     | out       | rsp_valid/rsp_stall| first_id, second_id, predicted, last
// csr_     | in        | csr_write          | csr_index, csr_data
//
// One request at a time. An eligible request passes through projection (three axes through
// one pipelined projection unit), scan (the slot chain rotates once past one pair comparator),
// emission (two hit bits per slot, the chain rotates again) and a store step. A skipped
// request never leaves idle. Reset clears control state and the configuration registers only.
// A stall on rsp_ holds emission while an alert waits; req_stall stays high through store.
module pairwise_separation_checker #(
   parameter int MAX_SLOTS = psc_pkg::DEF_MAX_SLOTS
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire                                    req_frame_start,
   input  wire        [psc_pkg::ID_W-1:0]         req_flight_id,
   input  wire        [psc_pkg::TIME_W-1:0]       req_entry_time,
   input  wire        [psc_pkg::TIME_W-1:0]       req_frame_time,
   input  wire signed [psc_pkg::POS_W-1:0]        req_pos_x,
   input  wire signed [psc_pkg::POS_W-1:0]        req_pos_y,
   input  wire signed [psc_pkg::POS_W-1:0]        req_pos_z,
   input  wire signed [psc_pkg::POS_W-1:0]        req_vel_x,
   input  wire signed [psc_pkg::POS_W-1:0]        req_vel_y,
   input  wire signed [psc_pkg::POS_W-1:0]        req_vel_z,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic       [psc_pkg::ID_W-1:0]         rsp_first_id,
   output logic       [psc_pkg::ID_W-1:0]         rsp_second_id,
   output logic                                   rsp_predicted,
   output logic                                   rsp_last,
   input  wire                                    csr_write,
   input  wire        [1:0]                       csr_index,
   input  wire        [psc_pkg::LIMIT_W-1:0]      csr_data
);
   import psc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int IDX_W  = $clog2(MAX_SLOTS);
   localparam int SCAN_W = $clog2(MAX_SLOTS + CMP_LAT + 1);
   localparam int HIT_W  = 2 * MAX_SLOTS;
   localparam int ALR_W  = $clog2(MAX_ALERTS + 1);
   localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(MAX_SLOTS + CMP_LAT - 1);

   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_DONE = 2'd3;

   // configuration
   logic [LIMIT_W-1:0]   hlim_ff, vlim_ff;
   logic [LOOK_W-1:0]    look_ff;
   logic [2*LIMIT_W-1:0] hl2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hlim_ff <= HLIMIT_RESET;
         vlim_ff <= VLIMIT_RESET;
         look_ff <= LOOK_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HLIMIT: hlim_ff <= csr_data;
            CSR_VLIMIT: vlim_ff <= csr_data;
            CSR_LOOK:   look_ff <= csr_data[LOOK_W-1:0];
            default:    ;
         endcase
      end
   end

   // control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           feed_ff, feed_in;
   logic [1:0]           ret_ff, ret_in;
   logic [SCAN_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]     eslot_ff, eslot_in;
   logic                 ebit_ff, ebit_in;
   logic [ALR_W-1:0]     alerts_ff, alerts_in;
   logic [HIT_W-1:0]     hits_ff, hits_in;
   logic                 rvalid_ff, rvalid_in;

   // request payload, held for the whole request
   logic [ID_W-1:0]      id_ff;
   pos_type              cur_ff, vel_ff, pred_ff, pred_in;
   logic [ID_W-1:0]      rfirst_ff, rsecond_ff;
   logic                 rpred_ff, rlast_ff, rload;

   // slot chain
   slot_type             cell_q [MAX_SLOTS];
   slot_type             new_slot;
   logic                 rotate, store;

   // projection and comparison
   logic                    pj_valid, pj_out_valid;
   logic signed [POS_W-1:0] pj_pos, pj_vel, pj_out;
   logic                    cmp_valid, cmp_out_valid, hit_cur, hit_pred;
   logic [IDX_W-1:0]        cmp_out_tag;

   logic accept, eligible, free, want;

   assign accept    = req_valid && !req_stall;
   assign eligible  = (req_flight_id != '0) && (req_entry_time <= req_frame_time);
   assign req_stall = (state_ff != ST_IDLE);
   assign free      = !rvalid_ff || !rsp_stall;
   assign want      = hits_ff[0] && (alerts_ff < ALR_W'(MAX_ALERTS));
   assign new_slot  = '{id: id_ff, cur: cur_ff, pred: pred_ff};

   always_comb begin
      unique case (feed_ff)
         AXIS_X:  begin pj_pos = cur_ff.x; pj_vel = vel_ff.x; end
         AXIS_Y:  begin pj_pos = cur_ff.y; pj_vel = vel_ff.y; end
         default: begin pj_pos = cur_ff.z; pj_vel = vel_ff.z; end
      endcase
   end

   always_comb begin
      pred_in = pred_ff;
      if (pj_out_valid) begin
         unique case (ret_ff)
            AXIS_X:  pred_in.x = pj_out;
            AXIS_Y:  pred_in.y = pj_out;
            default: pred_in.z = pj_out;
         endcase
      end
   end

   // next state and datapath controls
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      feed_in   = feed_ff;
      ret_in    = ret_ff;
      scan_in   = scan_ff;
      eslot_in  = eslot_ff;
      ebit_in   = ebit_ff;
      alerts_in = alerts_ff;
      hits_in   = hits_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      pj_valid  = 1'b0;
      cmp_valid = 1'b0;
      rotate    = 1'b0;
      store     = 1'b0;
      rload     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_frame_start) begin
                  count_in = '0;
               end
               feed_in = AXIS_X;
               ret_in  = AXIS_X;
               if (eligible) begin
                  state_in = ST_PROJ;
               end
            end
         end
         ST_PROJ: begin
            // feed three axes, collect three results in order
            if (feed_ff != AXIS_DONE) begin
               pj_valid = 1'b1;
               feed_in  = feed_ff + 2'd1;
            end
            if (pj_out_valid) begin
               ret_in = ret_ff + 2'd1;
               if (ret_ff == AXIS_Z) begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
                  hits_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            // rotate the chain once past the comparator, then drain it
            if (scan_ff < SCAN_W'(MAX_SLOTS)) begin
               rotate    = 1'b1;
               cmp_valid = (CNT_W'(scan_ff) < count_ff);
            end
            if (cmp_out_valid) begin
               hits_in[{cmp_out_tag, 1'b0}] = hit_cur;
               hits_in[{cmp_out_tag, 1'b1}] = hit_pred;
            end
            scan_in = scan_ff + SCAN_W'(1);
            if (scan_ff == SCAN_END) begin
               state_in  = ST_EMIT;
               eslot_in  = '0;
               ebit_in   = 1'b0;
               alerts_in = '0;
            end
         end
         ST_EMIT: begin
            // hold while a wanted alert finds the output register full
            if (!want || free) begin
               if (want) begin
                  rload     = 1'b1;
                  rvalid_in = 1'b1;
                  alerts_in = alerts_ff + ALR_W'(1);
               end
               hits_in = hits_ff >> 1;
               ebit_in = !ebit_ff;
               if (ebit_ff) begin
                  rotate   = 1'b1;
                  eslot_in = eslot_ff + IDX_W'(1);
                  if (eslot_ff == IDX_W'(MAX_SLOTS - 1)) begin
                     state_in = ST_STORE;
                  end
               end
            end
         end
         ST_STORE: begin
            if (count_ff < CNT_W'(MAX_SLOTS)) begin
               store    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         feed_ff   <= AXIS_DONE;
         ret_ff    <= AXIS_X;
         scan_ff   <= '0;
         eslot_ff  <= '0;
         ebit_ff   <= 1'b0;
         alerts_ff <= '0;
         hits_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         feed_ff   <= feed_in;
         ret_ff    <= ret_in;
         scan_ff   <= scan_in;
         eslot_ff  <= eslot_in;
         ebit_ff   <= ebit_in;
         alerts_ff <= alerts_in;
         hits_ff   <= hits_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // payload registers; the alert register keeps both ids while it waits
   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff  <= req_flight_id;
         cur_ff <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
         vel_ff <= '{x: req_vel_x, y: req_vel_y, z: req_vel_z};
         hl2_ff <= (2*LIMIT_W)'(hlim_ff) * (2*LIMIT_W)'(hlim_ff);
      end
      pred_ff <= pred_in;
      if (rload) begin
         rfirst_ff  <= cell_q[0].id;
         rsecond_ff <= id_ff;
         rpred_ff   <= ebit_ff;
         rlast_ff   <= (alerts_ff == ALR_W'(MAX_ALERTS - 1)) || !(|hits_ff[HIT_W-1:1]);
      end
   end

   assign rsp_valid     = rvalid_ff;
   assign rsp_first_id  = rfirst_ff;
   assign rsp_second_id = rsecond_ff;
   assign rsp_predicted = rpred_ff;
   assign rsp_last      = rlast_ff;

   // slot chain: cell 0 is the head; each cell takes its upper neighbor's slot
   for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
      psc_cell u_cell (
         .clock     (clock),
         .load      (store && (count_ff == CNT_W'(k))),
         .shift     (rotate),
         .load_data (new_slot),
         .next_data (cell_q[(k + 1) % MAX_SLOTS]),
         .slot_q    (cell_q[k])
      );
   end

   psc_project u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pj_valid),
      .in_pos    (pj_pos),
      .in_vel    (pj_vel),
      .look      (look_ff),
      .out_valid (pj_out_valid),
      .out_pos   (pj_out)
   );

   psc_compare #(
      .TAG_W (IDX_W)
   ) u_compare (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmp_valid),
      .in_tag    (scan_ff[IDX_W-1:0]),
      .a_cur     (cell_q[0].cur),
      .b_cur     (cur_ff),
      .a_pred    (cell_q[0].pred),
      .b_pred    (pred_ff),
      .hl2       (hl2_ff),
      .vl        (vlim_ff),
      .out_valid (cmp_out_valid),
      .out_tag   (cmp_out_tag),
      .hit_cur   (hit_cur),
      .hit_pred  (hit_pred)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/psc_cell.sv =====
`default_nettype none
module psc_cell (
   input  wire               clock,
   input  wire               load,
   input  wire               shift,
   input  psc_pkg::slot_type load_data,
   input  psc_pkg::slot_type next_data,
   output psc_pkg::slot_type slot_q
);
   import psc_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   // take a new record, or the neighbor's slot when the chain advances
   always_comb begin
      slot_in = slot_ff;
      if (load) begin
         slot_in = load_data;
      end else if (shift) begin
         slot_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_q = slot_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/psc_project.sv =====
`default_nettype none
module psc_project (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                in_valid,
   input  wire signed [psc_pkg::POS_W-1:0]    in_pos,
   input  wire signed [psc_pkg::POS_W-1:0]    in_vel,
   input  wire        [psc_pkg::LOOK_W-1:0]   look,
   output logic                               out_valid,
   output logic signed [psc_pkg::POS_W-1:0]   out_pos
);
   import psc_pkg::*;

   localparam int M_W = POS_W + LOOK_W;
   localparam int Q_W = 21;
   localparam int SHIFT = 43;
   localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / 64'(SECONDS_PER_HOUR));
   localparam logic [M_W:0] SPH = (M_W+1)'(SECONDS_PER_HOUR);
   localparam logic signed [POS_W+1:0] POS_HI = (POS_W+2)'((1 << (POS_W-1)) - 1);
   localparam logic signed [POS_W+1:0] POS_LO = -(POS_W+2)'(1 << (POS_W-1));

   logic [PROJ_LAT-1:0] vld_ff;

   logic                    neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic signed [POS_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic [M_W-1:0]          m1_ff, m2_ff, m3_ff;
   logic [63:0]             prod_ff;
   logic [Q_W-1:0]          q0_ff, q_ff;
   logic signed [POS_W-1:0] res_ff;

   logic [POS_W-1:0]        mag_in;
   logic [M_W:0]            rem_in;
   logic [Q_W-1:0]          q_in;
   logic signed [POS_W+1:0] sum_in;
   logic signed [POS_W+1:0] qs_in;
   logic signed [POS_W-1:0] res_in;

   always_comb begin
      mag_in = in_vel[POS_W-1] ? POS_W'(-in_vel) : POS_W'(in_vel);
      rem_in = {1'b0, m3_ff} - (M_W+1)'(q0_ff * SPH);
      q_in   = (rem_in >= SPH) ? q0_ff + Q_W'(1) : q0_ff;
      qs_in  = neg4_ff ? -(POS_W+2)'(q_ff) : (POS_W+2)'(q_ff);
      sum_in = (POS_W+2)'(p4_ff) + qs_in;
      if (sum_in > POS_HI) begin
         res_in = POS_HI[POS_W-1:0];
      end else if (sum_in < POS_LO) begin
         res_in = POS_LO[POS_W-1:0];
      end else begin
         res_in = sum_in[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PROJ_LAT-2:0], in_valid};
      end
   end

   // magnitude times lookahead, reciprocal multiply, correct, sign and saturate
   always_ff @(posedge clock) begin
      neg1_ff <= in_vel[POS_W-1];
      p1_ff   <= in_pos;
      m1_ff   <= M_W'(mag_in) * M_W'(look);
      neg2_ff <= neg1_ff;
      p2_ff   <= p1_ff;
      m2_ff   <= m1_ff;
      prod_ff <= 64'(m1_ff) * 64'(RECIP);
      neg3_ff <= neg2_ff;
      p3_ff   <= p2_ff;
      m3_ff   <= m2_ff;
      q0_ff   <= Q_W'(prod_ff >> SHIFT);
      neg4_ff <= neg3_ff;
      p4_ff   <= p3_ff;
      q_ff    <= q_in;
      res_ff  <= res_in;
   end

   assign out_valid = vld_ff[PROJ_LAT-1];
   assign out_pos   = res_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/psc_compare.sv =====
`default_nettype none
module psc_compare #(
   parameter int TAG_W = 5
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   input  wire [TAG_W-1:0]                  in_tag,
   input  psc_pkg::pos_type                 a_cur,
   input  psc_pkg::pos_type                 b_cur,
   input  psc_pkg::pos_type                 a_pred,
   input  psc_pkg::pos_type                 b_pred,
   input  wire [2*psc_pkg::LIMIT_W-1:0]     hl2,
   input  wire [psc_pkg::LIMIT_W-1:0]       vl,
   output logic                             out_valid,
   output logic [TAG_W-1:0]                 out_tag,
   output logic                             hit_cur,
   output logic                             hit_pred
);
   import psc_pkg::*;

   localparam int D_W = POS_W + 1;
   localparam int S_W = 2 * D_W;

   logic [CMP_LAT-1:0] vld_ff;
   logic [TAG_W-1:0]   tag1_ff, tag2_ff, tag3_ff;

   pos_type a [2];
   pos_type b [2];

   logic signed [D_W-1:0] dx_ff [2], dy_ff [2];
   logic signed [D_W-1:0] dx_in [2], dy_in [2], dz_in [2];
   logic [D_W-1:0]        adz_in [2];
   logic                  zok1_ff [2], zok2_ff [2], zok_in [2];
   logic signed [S_W-1:0] sqx_in [2], sqy_in [2];
   logic [S_W-1:0]        sqx_ff [2], sqy_ff [2];
   logic [S_W:0]          h2_in [2];
   logic                  hit_ff [2], hit_in [2];

   assign a[0] = a_cur;
   assign b[0] = b_cur;
   assign a[1] = a_pred;
   assign b[1] = b_pred;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         dx_in[l]  = {a[l].x[POS_W-1], a[l].x} - {b[l].x[POS_W-1], b[l].x};
         dy_in[l]  = {a[l].y[POS_W-1], a[l].y} - {b[l].y[POS_W-1], b[l].y};
         dz_in[l]  = {a[l].z[POS_W-1], a[l].z} - {b[l].z[POS_W-1], b[l].z};
         adz_in[l] = dz_in[l][D_W-1] ? D_W'(-dz_in[l]) : D_W'(dz_in[l]);
         zok_in[l] = adz_in[l] < D_W'(vl);
         sqx_in[l] = dx_ff[l] * dx_ff[l];
         sqy_in[l] = dy_ff[l] * dy_ff[l];
         h2_in[l]  = {1'b0, sqx_ff[l]} + {1'b0, sqy_ff[l]};
         hit_in[l] = (h2_in[l] < (S_W+1)'(hl2)) && zok2_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[CMP_LAT-2:0], in_valid};
      end
   end

   // differences, then squares, then sum and compare
   always_ff @(posedge clock) begin
      tag1_ff <= in_tag;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      for (int l = 0; l < 2; l++) begin
         dx_ff[l]   <= dx_in[l];
         dy_ff[l]   <= dy_in[l];
         zok1_ff[l] <= zok_in[l];
         sqx_ff[l]  <= sqx_in[l];
         sqy_ff[l]  <= sqy_in[l];
         zok2_ff[l] <= zok1_ff[l];
         hit_ff[l]  <= hit_in[l];
      end
   end

   assign out_valid = vld_ff[CMP_LAT-1];
   assign out_tag   = tag3_ff;
   assign hit_cur   = hit_ff[0];
   assign hit_pred  = hit_ff[1];

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
   import psc_pkg::*;

   localparam int NSLOTS     = DEF_MAX_SLOTS;
   localparam int DRAIN_WAIT = 2 * NSLOTS + MAX_ALERTS + 40;
   localparam int HOLD_CYCLES = 400;
   localparam longint POS_HI = 8388607;
   localparam longint POS_LO = -8388608;

   // one request as the sender offers it
   typedef struct {
      logic                    frame_start;
      logic [ID_W-1:0]         flight_id;
      logic [TIME_W-1:0]       entry_time;
      logic [TIME_W-1:0]       frame_time;
      logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
      logic signed [POS_W-1:0] vel_x, vel_y, vel_z;
   } track_req_type;

   // one expected alert
   typedef struct {
      logic [ID_W-1:0] first_id;
      logic [ID_W-1:0] second_id;
      logic            predicted;
      logic            last;
   } alert_type;

   // directed row: request plus alert count typed in, -1 when left to the predictor
   typedef struct {
      track_req_type rq;
      int            n_alerts;
   } directed_row_type;

   // tracked aircraft as the predictor keeps them
   typedef struct {
      logic [ID_W-1:0] id;
      longint cx, cy, cz;
      longint px, py, pz;
   } track_slot_type;

   logic clock = 1'b0;
   logic reset;

   logic                    req_valid;
   logic                    req_stall;
   logic                    req_frame_start;
   logic [ID_W-1:0]         req_flight_id;
   logic [TIME_W-1:0]       req_entry_time;
   logic [TIME_W-1:0]       req_frame_time;
   logic signed [POS_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [POS_W-1:0] req_vel_x, req_vel_y, req_vel_z;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [ID_W-1:0]         rsp_first_id;
   logic [ID_W-1:0]         rsp_second_id;
   logic                    rsp_predicted;
   logic                    rsp_last;
   logic                    csr_write;
   logic [1:0]              csr_index;
   logic [LIMIT_W-1:0]      csr_data;

   // predictor state: its own copy of the store and of the registers
   track_slot_type  tracked[NSLOTS];
   int unsigned     tracked_count;
   longint          h_limit, v_limit, look_sec;

   alert_type       pending_alerts[$];
   int              alerts_of_last;
   int              error_count;
   int              requests_sent;
   int              alerts_seen;
   int              phases_run;
   bit              gap_on;
   bit              stall_on;
   bit              hold_long;

   // random frame generation
   int              frame_left;
   bit              dense_next;
   bit              dense_frame;
   logic [TIME_W-1:0] frame_clock;
   longint          base_x, base_y, base_z;

   directed_row_type directed[$];

   pairwise_separation_checker DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_frame_start(req_frame_start), .req_flight_id(req_flight_id),
      .req_entry_time(req_entry_time), .req_frame_time(req_frame_time),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_vel_z(req_vel_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_first_id(rsp_first_id), .rsp_second_id(rsp_second_id),
      .rsp_predicted(rsp_predicted), .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #30ms;
      $display("tb: done, errors");
      $finish;
   end

   task automatic report(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // advance one axis by the lookahead, truncating toward zero, then clamp
   function automatic longint project_axis(input longint p, input longint v);
      longint r;
      r = p + (v * look_sec) / SECONDS_PER_HOUR;
      if (r > POS_HI) r = POS_HI;
      if (r < POS_LO) r = POS_LO;
      return r;
   endfunction

   function automatic bit too_close(input longint ax, input longint ay, input longint az,
                                    input longint bx, input longint by, input longint bz);
      longint dx, dy, dz, h2;
      dx = ax - bx;
      dy = ay - by;
      dz = az - bz;
      h2 = dx * dx + dy * dy;
      if (dz < 0) dz = -dz;
      return (h2 < h_limit * h_limit) && (dz < v_limit);
   endfunction

   // work out the alerts one accepted request causes and update the store
   function automatic int predict_alerts(input track_req_type r);
      track_slot_type nw;
      alert_type      a;
      int             n;
      bit             hit;
      n = 0;
      if (r.frame_start) tracked_count = 0;
      if (r.flight_id == 0 || r.entry_time > r.frame_time) return 0;
      nw.id = r.flight_id;
      nw.cx = longint'(r.pos_x);
      nw.cy = longint'(r.pos_y);
      nw.cz = longint'(r.pos_z);
      nw.px = project_axis(nw.cx, longint'(r.vel_x));
      nw.py = project_axis(nw.cy, longint'(r.vel_y));
      nw.pz = project_axis(nw.cz, longint'(r.vel_z));
      for (int i = 0; i < tracked_count; i++) begin
         for (int k = 0; k < 2; k++) begin
            hit = (k == 0)
               ? too_close(tracked[i].cx, tracked[i].cy, tracked[i].cz, nw.cx, nw.cy, nw.cz)
               : too_close(tracked[i].px, tracked[i].py, tracked[i].pz, nw.px, nw.py, nw.pz);
            // drop alerts past the per-request cap
            if (hit && n < MAX_ALERTS) begin
               a.first_id  = tracked[i].id;
               a.second_id = r.flight_id;
               a.predicted = k[0];
               a.last      = 1'b0;
               pending_alerts.push_back(a);
               n++;
            end
         end
      end
      if (n > 0) pending_alerts[pending_alerts.size() - 1].last = 1'b1;
      // a full store still checks but does not keep the record
      if (tracked_count < NSLOTS) begin
         tracked[tracked_count] = nw;
         tracked_count++;
      end
      return n;
   endfunction

   // request side: predict on every accepted request
   always @(posedge clock) begin
      track_req_type r;
      if (!reset && req_valid && !req_stall) begin
         r.frame_start = req_frame_start;
         r.flight_id   = req_flight_id;
         r.entry_time  = req_entry_time;
         r.frame_time  = req_frame_time;
         r.pos_x = req_pos_x; r.pos_y = req_pos_y; r.pos_z = req_pos_z;
         r.vel_x = req_vel_x; r.vel_y = req_vel_y; r.vel_z = req_vel_z;
         alerts_of_last = predict_alerts(r);
         requests_sent++;
      end
   end

   // result side: compare each accepted alert with the oldest expectation
   always @(posedge clock) begin
      alert_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         alerts_seen++;
         if (pending_alerts.size() == 0) begin
            report($sformatf("unexpected alert %0d/%0d", rsp_first_id, rsp_second_id));
         end else begin
            e = pending_alerts.pop_front();
            if (rsp_first_id !== e.first_id)
               report($sformatf("first_id %0d, want %0d", rsp_first_id, e.first_id));
            if (rsp_second_id !== e.second_id)
               report($sformatf("second_id %0d, want %0d", rsp_second_id, e.second_id));
            if (rsp_predicted !== e.predicted)
               report($sformatf("predicted %0b, want %0b", rsp_predicted, e.predicted));
            if (rsp_last !== e.last)
               report($sformatf("last %0b, want %0b", rsp_last, e.last));
         end
      end
   end

   // receiver: random stall per alert, plus one long hold-off on request
   initial begin
      int w;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_long = 1'b0;
         end
         w = stall_on ? $urandom_range(0, 12) : 0;
         if (w > 0) begin
            rsp_stall = 1'b1;
            repeat (w) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input track_req_type r);
      int gap;
      gap = gap_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_frame_start = r.frame_start;
      req_flight_id   = r.flight_id;
      req_entry_time  = r.entry_time;
      req_frame_time  = r.frame_time;
      req_pos_x = r.pos_x; req_pos_y = r.pos_y; req_pos_z = r.pos_z;
      req_vel_x = r.vel_x; req_vel_y = r.vel_y; req_vel_z = r.vel_z;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [LIMIT_W-1:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_HLIMIT: h_limit  = longint'(val);
         CSR_VLIMIT: v_limit  = longint'(val);
         CSR_LOOK:   look_sec = longint'(val[LOOK_W-1:0]);
         default: ;
      endcase
   endtask

   // drain every expected alert, then let a zero-alert request finish too
   task automatic wait_quiet();
      req_valid = 1'b0;
      while (pending_alerts.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic track_req_type make_row(input logic fs, input int id,
         input logic [TIME_W-1:0] et, input logic [TIME_W-1:0] ft,
         input longint px, input longint py, input longint pz,
         input longint vx, input longint vy, input longint vz);
      track_req_type r;
      r.frame_start = fs;
      r.flight_id = ID_W'(id);
      r.entry_time = et;
      r.frame_time = ft;
      r.pos_x = POS_W'(px); r.pos_y = POS_W'(py); r.pos_z = POS_W'(pz);
      r.vel_x = POS_W'(vx); r.vel_y = POS_W'(vy); r.vel_z = POS_W'(vz);
      return r;
   endfunction

   function automatic void add_row(input track_req_type r, input int n);
      directed_row_type d;
      d.rq = r;
      d.n_alerts = n;
      directed.push_back(d);
   endfunction

   // clustered frames with random content, some noise and oversize frames
   function automatic track_req_type random_request();
      track_req_type r;
      r.frame_start = ($urandom_range(0, 49) == 0);
      if (frame_left == 0) begin
         dense_frame = dense_next;
         dense_next  = 1'b0;
         frame_left  = dense_frame ? NSLOTS + 2 : $urandom_range(1, 40);
         frame_clock = $urandom;
         base_x = longint'($urandom_range(0, 8000000)) - 4000000;
         base_y = longint'($urandom_range(0, 8000000)) - 4000000;
         base_z = longint'($urandom_range(0, 8000000)) - 4000000;
         r.frame_start = 1'b1;
      end
      frame_left--;
      r.frame_time = frame_clock;
      r.flight_id = ($urandom_range(0, 15) == 0) ? '0 : ID_W'($urandom_range(1, 65535));
      if (dense_frame) r.flight_id = ID_W'($urandom_range(1, 65535));
      if ($urandom_range(0, 9) == 0) r.entry_time = $urandom;
      else r.entry_time = $urandom_range(0, frame_clock);
      if (dense_frame) begin
         r.pos_x = POS_W'(base_x); r.pos_y = POS_W'(base_y); r.pos_z = POS_W'(base_z);
      end else if ($urandom_range(0, 7) == 0) begin
         r.pos_x = POS_W'($urandom); r.pos_y = POS_W'($urandom); r.pos_z = POS_W'($urandom);
      end else begin
         r.pos_x = POS_W'(base_x + $urandom_range(0, 8000) - 4000);
         r.pos_y = POS_W'(base_y + $urandom_range(0, 8000) - 4000);
         r.pos_z = POS_W'(base_z + $urandom_range(0, 3000) - 1500);
      end
      if ($urandom_range(0, 3) == 0) begin
         r.vel_x = POS_W'($urandom); r.vel_y = POS_W'($urandom); r.vel_z = POS_W'($urandom);
      end else begin
         r.vel_x = POS_W'(longint'($urandom_range(0, 400000)) - 200000);
         r.vel_y = POS_W'(longint'($urandom_range(0, 400000)) - 200000);
         r.vel_z = POS_W'(longint'($urandom_range(0, 60000)) - 30000);
      end
      return r;
   endfunction

   initial begin
      logic [TIME_W-1:0] tmax;
      logic [LIMIT_W-1:0] hl_set[5];
      logic [LIMIT_W-1:0] vl_set[5];
      logic [LIMIT_W-1:0] lk_set[5];
      int n_rand;
      tmax = '1;
      reset = 1'b1;
      req_valid = 1'b0;
      req_frame_start = 1'b0;
      req_flight_id = '0;
      req_entry_time = '0;
      req_frame_time = '0;
      req_pos_x = '0; req_pos_y = '0; req_pos_z = '0;
      req_vel_x = '0; req_vel_y = '0; req_vel_z = '0;
      csr_write = 1'b0;
      csr_index = CSR_HLIMIT;
      csr_data = '0;
      tracked_count = 0;
      h_limit = longint'(HLIMIT_RESET);
      v_limit = longint'(VLIMIT_RESET);
      look_sec = longint'(LOOK_RESET);
      error_count = 0;
      requests_sent = 0;
      alerts_seen = 0;
      alerts_of_last = 0;
      phases_run = 0;
      gap_on = 1'b1;
      stall_on = 1'b1;
      hold_long = 1'b0;
      frame_left = 0;
      dense_next = 1'b0;
      dense_frame = 1'b0;
      frame_clock = '0;
      base_x = 0; base_y = 0; base_z = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, on reset register values
      add_row(make_row(1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0);           // empty store
      add_row(make_row(0, 2, 0, 0, 0, 0, 0, 0, 0, 0), 2);           // same spot, both kinds
      add_row(make_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);           // id zero skipped
      add_row(make_row(0, 3, 5, 4, 0, 0, 0, 0, 0, 0), 0);           // not yet entered
      add_row(make_row(0, 4, tmax, tmax, 2999, 0, 999, 0, 0, 0), 4); // just inside both limits
      add_row(make_row(0, 5, 0, 0, 3000, 0, 0, 0, 0, 0), -1);       // on horizontal edge
      add_row(make_row(0, 6, 0, 0, 0, 0, 1000, 0, 0, 0), -1);       // on vertical edge
      add_row(make_row(0, 7, 0, 0, 0, 100000, 0, 0, -3000000, 0), -1); // projected closes in
      add_row(make_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);           // skipped, still clears
      add_row(make_row(0, 8, 0, 0, 0, 0, 0, 0, 0, 0), 0);           // store was cleared
      add_row(make_row(1, 65535, 0, tmax, POS_HI, POS_HI, POS_HI, POS_HI, POS_HI, POS_HI), 0);
      add_row(make_row(0, 9, 0, tmax, POS_HI, POS_HI, POS_HI, POS_LO, POS_LO, POS_LO), -1);
      add_row(make_row(0, 10, 0, 1, POS_LO, POS_LO, POS_LO, POS_LO, POS_LO, POS_LO), -1);
      add_row(make_row(0, 11, 0, 1, POS_LO, POS_LO, POS_LO, POS_HI, POS_HI, POS_HI), -1);
      add_row(make_row(0, 12, 1, 0, 0, 0, 0, 0, 0, 0), 0);          // entry one past frame
      add_row(make_row(0, 13, 0, 0, -1, -1, -1, -1, -1, -1), -1);   // truncation toward zero
      add_row(make_row(0, 14, 0, 0, 1, 1, 1, 1, 1, 1), -1);
      add_row(make_row(0, 15, tmax, tmax, 0, 0, 0, 0, 0, 0), -1);
      foreach (directed[i]) begin
         send_request(directed[i].rq);
         if (directed[i].n_alerts >= 0 && alerts_of_last != directed[i].n_alerts)
            report($sformatf("row %0d: %0d alerts, want %0d",
                             i, alerts_of_last, directed[i].n_alerts));
      end
      wait_quiet();

      // register settings per phase; zero limits and the maxima among them
      hl_set = '{23'd3000, 23'd0, 23'h7FFFFF, 23'd5000, 23'd1};
      vl_set = '{23'd1000, 23'd0, 23'h7FFFFF, 23'd2000, 23'd1};
      lk_set = '{23'd120, 23'd0, 23'd255, 23'd37, 23'd255};
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_HLIMIT, hl_set[ph]);
         write_reg(CSR_VLIMIT, vl_set[ph]);
         write_reg(CSR_LOOK, lk_set[ph]);
         frame_left = 0;
         // full store and alert cap come from a dense frame
         dense_next = (ph == 0 || ph == 2);
         n_rand = 66;
         for (int k = 0; k < n_rand; k++) begin
            if (k % 22 == 0) begin
               gap_on   = $urandom_range(0, 2) != 0;
               stall_on = $urandom_range(0, 2) != 0;
            end
            // hold off the receiver once while the sender keeps offering
            if (ph == 0 && k == 10) begin
               hold_long = 1'b1;
               gap_on    = 1'b0;
            end
            send_request(random_request());
         end
         // let a dense frame run to its end
         while (frame_left > 0 && dense_frame) send_request(random_request());
         wait_quiet();
         phases_run++;
      end

      if (pending_alerts.size() != 0)
         report($sformatf("%0d alerts never arrived", pending_alerts.size()));
      $display("tb: %0d requests over %0d register settings, %0d alerts checked",
               requests_sent, phases_run + 1, alerts_seen);
      $display("tb: covered skips, frame clears, full store, alert cap, saturation");
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
